// ===== sv/jme_pkg.sv =====
`timescale 1ns / 1ps
// jme_pkg: shared constants for the jackknife mean error estimator
// no dependencies

package jme_pkg;
    localparam int MAX_SAMPLES = 4096;
    localparam int MAX_BLOCKS  = 32;
    localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = SAMPLE_AW + 1;
    localparam int BLK_AW      = $clog2(MAX_BLOCKS);
    localparam int BCNT_W      = 6;
    localparam int DIV_NUM_W   = 64;
    localparam int DIV_DEN_W   = CNT_W;

    localparam logic [1:0] KIND_EST = 2'd0;
    localparam logic [1:0] KIND_UNB = 2'd1;
    localparam logic [1:0] KIND_SUB = 2'd2;

    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_UNBIASED    = 1'b1;
endpackage

// ===== sv/jme_ram.sv =====
`timescale 1ns / 1ps
// jme_ram: generic simple dual port ram, one write port, registered read
// no dependencies

module jme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/jme_div.sv =====
`timescale 1ns / 1ps
// jme_div: unsigned restoring divider, one quotient bit per cycle
// depends on jme_pkg

module jme_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [jme_pkg::DIV_NUM_W-1:0]  num,
    input  logic [jme_pkg::DIV_DEN_W-1:0]  den,
    output logic                           busy,
    output logic                           done,
    output logic [jme_pkg::DIV_NUM_W-1:0]  quo,
    output logic [jme_pkg::DIV_DEN_W-1:0]  rem
);
    import jme_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0]  quo_reg, quo_next;
    logic [DIV_DEN_W:0]    rem_reg, rem_next;
    logic [DIV_DEN_W-1:0]  den_reg, den_next;
    logic [DIV_DEN_W:0]    trial;

    // one restoring step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
        if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(DIV_NUM_W - 1);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[DIV_DEN_W-1:0];
endmodule

// ===== sv/jme_sqrt.sv =====
`timescale 1ns / 1ps
// jme_sqrt: 64-bit integer square root, two radicand bits per cycle
// no package dependencies

module jme_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    // digit-by-digit step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        trial     = r_reg + bit_reg;
        if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            v_next    = radicand;
            r_next    = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = r_reg[31:0];
endmodule

// ===== sv/jackknife_mean_error_estimator_core.sv =====
`timescale 1ns / 1ps
// Samples are stored in the sample ram while loading. After the sample marked last, the run is summed
// from the sample ram at one sample per cycle, then each mean, variance step and bias
// goes through the shared divider; the subset means are then read back and emitted while
// the output accepts, and the next run is taken once the last result is registered.
// Results: estimator item, then B subset means; one status item if n < B.
// Synchronous active-low reset returns to loading with an empty store, B = 1, plain mode.
// jackknife_mean_error_estimator_core: top level; depends on jme_pkg, jme_ram, jme_div,
// jme_sqrt

module jackknife_mean_error_estimator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // block_index, value, std_dev, zero pad
    output logic [2:0]  m_tuser,   // kind, status
    output logic        m_tlast
);
    import jme_pkg::*;

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_ERR    = 5'd1;
    localparam logic [4:0] S_NDIV   = 5'd2;
    localparam logic [4:0] S_SUM    = 5'd3;
    localparam logic [4:0] S_ESTGO  = 5'd4;
    localparam logic [4:0] S_ESTW   = 5'd5;
    localparam logic [4:0] S_SUBRD  = 5'd6;
    localparam logic [4:0] S_SUBDAT = 5'd7;
    localparam logic [4:0] S_SUBW   = 5'd8;
    localparam logic [4:0] S_SUBWR  = 5'd9;
    localparam logic [4:0] S_SQ1    = 5'd10;
    localparam logic [4:0] S_SQ2    = 5'd11;
    localparam logic [4:0] S_VGO    = 5'd12;
    localparam logic [4:0] S_V1W    = 5'd13;
    localparam logic [4:0] S_V2W    = 5'd14;
    localparam logic [4:0] S_SQW    = 5'd15;
    localparam logic [4:0] S_BGO    = 5'd16;
    localparam logic [4:0] S_BW     = 5'd17;
    localparam logic [4:0] S_RES    = 5'd18;
    localparam logic [4:0] S_OUT0   = 5'd19;
    localparam logic [4:0] S_ERD    = 5'd20;
    localparam logic [4:0] S_EDAT   = 5'd21;

    logic [4:0]           state_reg, state_next;
    logic [BCNT_W-1:0]    blk_cfg_reg, blk_cfg_next;
    logic                 unb_reg, unb_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [BCNT_W-1:0]    b_reg, b_next;
    logic [CNT_W-1:0]     m_reg, m_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [BLK_AW-1:0]    k_reg, k_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic signed [44:0]   acc_reg, acc_next;
    logic signed [44:0]   total_reg, total_next;
    logic [CNT_W-1:0]     den_est_reg, den_est_next;
    logic [CNT_W-1:0]     den_sub_reg, den_sub_next;
    logic signed [31:0]   est_reg, est_next;
    logic signed [31:0]   sm_reg, sm_next;
    logic signed [37:0]   bsum_reg, bsum_next;
    logic [31:0]          ad_reg, ad_next;
    logic [63:0]          d2_reg, d2_next;
    logic [63:0]          sq_reg, sq_next;
    logic [63:0]          t_reg, t_next;
    logic [30:0]          sd_reg, sd_next;
    logic signed [31:0]   res_reg, res_next;
    logic                 div_start_reg, div_start_next;
    logic [DIV_NUM_W-1:0] div_num_reg, div_num_next;
    logic [DIV_DEN_W-1:0] div_den_reg, div_den_next;
    logic                 div_neg_reg, div_neg_next;
    logic                 sq_start_reg, sq_start_next;
    logic [63:0]          sq_in_reg, sq_in_next;
    logic                 ov_reg, ov_next;
    logic [1:0]           okind_reg, okind_next;
    logic [BLK_AW-1:0]    oidx_reg, oidx_next;
    logic [31:0]          oval_reg, oval_next;
    logic [30:0]          osd_reg, osd_next;
    logic                 ost_reg, ost_next;
    logic                 oeor_reg, oeor_next;

    logic                 div_busy, div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [DIV_DEN_W-1:0] div_rem;
    logic                 sqrt_busy, sqrt_done;
    logic [31:0]          sqrt_root;

    logic                 smp_we;
    logic [31:0]          smp_rdata;
    logic                 bs_we;
    logic [63:0]          bs_wdata;
    logic [63:0]          bs_rdata;
    logic                 sm_we;
    logic [31:0]          sm_rdata;

    logic                 in_acc, out_free, full;
    logic [CNT_W-1:0]     n_cur;
    logic [BCNT_W-1:0]    b_cl;
    logic [1:0]           kind0;
    logic signed [44:0]   blk_s;
    logic signed [45:0]   sub_num;
    logic [45:0]          sub_mag;
    logic [44:0]          tot_mag;
    logic [37:0]          bs_mag;
    logic signed [31:0]   q_signed;
    logic signed [32:0]   dev;
    logic [64:0]          sq_sum;
    logic signed [32:0]   bias_d;
    logic signed [38:0]   res_w;
    logic [BLK_AW-1:0]    bm1;

    // memories: samples, block sums, subset means
    jme_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_smp (
        .aclk(aclk), .we(smp_we), .waddr(cnt_reg[SAMPLE_AW-1:0]), .wdata(s_tdata),
        .raddr(idx_reg[SAMPLE_AW-1:0]), .rdata(smp_rdata)
    );
    jme_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_bsum (
        .aclk(aclk), .we(bs_we), .waddr(k_reg), .wdata(bs_wdata),
        .raddr(k_reg), .rdata(bs_rdata)
    );
    jme_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_smean (
        .aclk(aclk), .we(sm_we), .waddr(k_reg), .wdata(sm_reg),
        .raddr(k_reg), .rdata(sm_rdata)
    );

    jme_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg), .num(div_num_reg),
        .den(div_den_reg), .busy(div_busy), .done(div_done), .quo(div_quo), .rem(div_rem)
    );

    jme_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start_reg), .radicand(sq_in_reg),
        .busy(sqrt_busy), .done(sqrt_done), .root(sqrt_root)
    );

    // handshake and helpers
    assign s_tready = (state_reg == S_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;
    assign full     = (cnt_reg == CNT_W'(MAX_SAMPLES));
    assign n_cur    = full ? cnt_reg : cnt_reg + 1'b1;
    assign kind0    = unb_reg ? KIND_UNB : KIND_EST;
    assign bm1      = BLK_AW'(b_reg - 1'b1);
    assign smp_we   = in_acc && !full;
    assign blk_s    = acc_reg + {{13{smp_rdata[31]}}, smp_rdata};
    assign bs_wdata = {{19{blk_s[44]}}, blk_s};
    assign sub_num  = {total_reg[44], total_reg} - $signed(bs_rdata[45:0]);
    assign sub_mag  = sub_num[45] ? 46'(-sub_num) : 46'(sub_num);
    assign tot_mag  = total_reg[44] ? 45'(-total_reg) : 45'(total_reg);
    assign bs_mag   = bsum_reg[37] ? 38'(-bsum_reg) : 38'(bsum_reg);
    assign q_signed = div_neg_reg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
    assign dev      = {sm_reg[31], sm_reg} - {est_reg[31], est_reg};
    assign sq_sum   = {1'b0, sq_reg} + {1'b0, d2_reg};
    assign bias_d   = {sm_reg[31], sm_reg} - {est_reg[31], est_reg};
    assign res_w    = {{7{est_reg[31]}}, est_reg}
                      - 39'(bias_d) * 39'($signed({1'b0, bm1}));

    always_comb begin
        if (blk_cfg_reg == '0) begin
            b_cl = BCNT_W'(1);
        end else if (blk_cfg_reg > BCNT_W'(MAX_BLOCKS)) begin
            b_cl = BCNT_W'(MAX_BLOCKS);
        end else begin
            b_cl = blk_cfg_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        blk_cfg_next   = blk_cfg_reg;
        unb_next       = unb_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        b_next         = b_reg;
        m_next         = m_reg;
        idx_next       = idx_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        rd_vld_next    = 1'b0;
        acc_next       = acc_reg;
        total_next     = total_reg;
        den_est_next   = den_est_reg;
        den_sub_next   = den_sub_reg;
        est_next       = est_reg;
        sm_next        = sm_reg;
        bsum_next      = bsum_reg;
        ad_next        = ad_reg;
        d2_next        = d2_reg;
        sq_next        = sq_reg;
        t_next         = t_reg;
        sd_next        = sd_reg;
        res_next       = res_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_neg_next   = div_neg_reg;
        sq_start_next  = 1'b0;
        sq_in_next     = sq_in_reg;
        ov_next        = ov_reg && !m_tready;
        okind_next     = okind_reg;
        oidx_next      = oidx_reg;
        oval_next      = oval_reg;
        osd_next       = osd_reg;
        ost_next       = ost_reg;
        oeor_next      = oeor_reg;
        bs_we          = 1'b0;
        sm_we          = 1'b0;

        // configuration writes
        if (cfg_we) begin
            if (cfg_addr == REG_BLOCK_COUNT) begin
                blk_cfg_next = cfg_wdata;
            end else if (cfg_addr == REG_UNBIASED) begin
                unb_next = cfg_wdata[0];
            end
        end

        case (state_reg)
            // store samples, start on last
            S_LOAD: begin
                if (in_acc) begin
                    if (!full) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        cnt_next = '0;
                        n_next   = n_cur;
                        b_next   = b_cl;
                        if (n_cur < CNT_W'(b_cl)) begin
                            state_next = S_ERR;
                        end else begin
                            div_start_next = 1'b1;
                            div_num_next   = DIV_NUM_W'(n_cur);
                            div_den_next   = DIV_DEN_W'(b_cl);
                            div_neg_next   = 1'b0;
                            state_next     = S_NDIV;
                        end
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = kind0;
                    oidx_next  = '0;
                    oval_next  = '0;
                    osd_next   = '0;
                    ost_next   = 1'b1;
                    oeor_next  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            // block length and dropped head
            S_NDIV: begin
                if (div_done) begin
                    m_next       = div_quo[CNT_W-1:0];
                    idx_next     = CNT_W'(div_rem);
                    den_est_next = CNT_W'(div_quo[CNT_W-1:0] * b_reg);
                    den_sub_next = CNT_W'(div_quo[CNT_W-1:0] * bm1);
                    i_next       = '0;
                    k_next       = '0;
                    acc_next     = '0;
                    total_next   = '0;
                    state_next   = S_SUM;
                end
            end
            // stream samples out of the store, one per cycle
            S_SUM: begin
                if (idx_reg < n_reg) begin
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    if (i_reg + 1'b1 == m_reg) begin
                        bs_we      = 1'b1;
                        total_next = total_reg + blk_s;
                        acc_next   = '0;
                        i_next     = '0;
                        k_next     = k_reg + 1'b1;
                        if (k_reg == bm1) begin
                            k_next     = '0;
                            state_next = S_ESTGO;
                        end
                    end else begin
                        acc_next = blk_s;
                        i_next   = i_reg + 1'b1;
                    end
                end
            end
            S_ESTGO: begin
                div_start_next = 1'b1;
                div_num_next   = DIV_NUM_W'(tot_mag) + DIV_NUM_W'(den_est_reg >> 1);
                div_den_next   = den_est_reg;
                div_neg_next   = total_reg[44];
                state_next     = S_ESTW;
            end
            S_ESTW: begin
                if (div_done) begin
                    est_next   = q_signed;
                    bsum_next  = '0;
                    sq_next    = '0;
                    state_next = S_SUBRD;
                end
            end
            // leave-one-block-out means
            S_SUBRD: begin
                state_next = S_SUBDAT;
            end
            S_SUBDAT: begin
                if (b_reg == BCNT_W'(1)) begin
                    sm_next    = '0;
                    state_next = S_SUBWR;
                end else begin
                    div_start_next = 1'b1;
                    div_num_next   = DIV_NUM_W'(sub_mag) + DIV_NUM_W'(den_sub_reg >> 1);
                    div_den_next   = den_sub_reg;
                    div_neg_next   = sub_num[45];
                    state_next     = S_SUBW;
                end
            end
            S_SUBW: begin
                if (div_done) begin
                    sm_next    = q_signed;
                    state_next = S_SUBWR;
                end
            end
            S_SUBWR: begin
                sm_we      = 1'b1;
                bsum_next  = bsum_reg + {{6{sm_reg[31]}}, sm_reg};
                ad_next    = dev[32] ? 32'(-dev) : dev[31:0];
                state_next = S_SQ1;
            end
            S_SQ1: begin
                d2_next    = ad_reg * ad_reg;
                state_next = S_SQ2;
            end
            S_SQ2: begin
                sq_next = sq_sum[64] ? '1 : sq_sum[63:0];
                k_next  = k_reg + 1'b1;
                if (k_reg == bm1) begin
                    k_next     = '0;
                    state_next = S_VGO;
                end else begin
                    state_next = S_SUBRD;
                end
            end
            // scale by (B-1)/B and take the root
            S_VGO: begin
                div_start_next = 1'b1;
                div_num_next   = sq_reg;
                div_den_next   = DIV_DEN_W'(b_reg);
                div_neg_next   = 1'b0;
                state_next     = S_V1W;
            end
            S_V1W: begin
                if (div_done) begin
                    t_next         = 64'(div_quo * bm1);
                    div_start_next = 1'b1;
                    div_num_next   = DIV_NUM_W'(div_rem[BCNT_W-1:0]) * DIV_NUM_W'(bm1);
                    div_den_next   = DIV_DEN_W'(b_reg);
                    state_next     = S_V2W;
                end
            end
            S_V2W: begin
                if (div_done) begin
                    sq_start_next = 1'b1;
                    sq_in_next    = t_reg + div_quo;
                    state_next    = S_SQW;
                end
            end
            S_SQW: begin
                if (sqrt_done) begin
                    sd_next = sqrt_root[31] ? 31'h7FFF_FFFF : sqrt_root[30:0];
                    if (unb_reg) begin
                        state_next = S_BGO;
                    end else begin
                        res_next   = est_reg;
                        state_next = S_OUT0;
                    end
                end
            end
            // bias correction
            S_BGO: begin
                div_start_next = 1'b1;
                div_num_next   = DIV_NUM_W'(bs_mag) + DIV_NUM_W'(b_reg >> 1);
                div_den_next   = DIV_DEN_W'(b_reg);
                div_neg_next   = bsum_reg[37];
                state_next     = S_BW;
            end
            S_BW: begin
                if (div_done) begin
                    sm_next    = q_signed;
                    state_next = S_RES;
                end
            end
            S_RES: begin
                if (res_w > 39'sd2147483647) begin
                    res_next = 32'sh7FFF_FFFF;
                end else if (res_w < -39'sd2147483648) begin
                    res_next = 32'sh8000_0000;
                end else begin
                    res_next = res_w[31:0];
                end
                state_next = S_OUT0;
            end
            // emit results
            S_OUT0: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = kind0;
                    oidx_next  = '0;
                    oval_next  = res_reg;
                    osd_next   = sd_reg;
                    ost_next   = 1'b0;
                    oeor_next  = 1'b0;
                    k_next     = '0;
                    state_next = S_ERD;
                end
            end
            S_ERD: begin
                state_next = S_EDAT;
            end
            S_EDAT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = KIND_SUB;
                    oidx_next  = k_reg;
                    oval_next  = sm_rdata;
                    osd_next   = '0;
                    ost_next   = 1'b0;
                    oeor_next  = (k_reg == bm1);
                    if (k_reg == bm1) begin
                        state_next = S_LOAD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            blk_cfg_reg   <= BCNT_W'(1);
            unb_reg       <= 1'b0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            div_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
            ov_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            blk_cfg_reg   <= blk_cfg_next;
            unb_reg       <= unb_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            div_start_reg <= div_start_next;
            sq_start_reg  <= sq_start_next;
            ov_reg        <= ov_next;
        end
        n_reg       <= n_next;
        b_reg       <= b_next;
        m_reg       <= m_next;
        idx_reg     <= idx_next;
        i_reg       <= i_next;
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        total_reg   <= total_next;
        den_est_reg <= den_est_next;
        den_sub_reg <= den_sub_next;
        est_reg     <= est_next;
        sm_reg      <= sm_next;
        bsum_reg    <= bsum_next;
        ad_reg      <= ad_next;
        d2_reg      <= d2_next;
        sq_reg      <= sq_next;
        t_reg       <= t_next;
        sd_reg      <= sd_next;
        res_reg     <= res_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_neg_reg <= div_neg_next;
        sq_in_reg   <= sq_in_next;
        okind_reg   <= okind_next;
        oidx_reg    <= oidx_next;
        oval_reg    <= oval_next;
        osd_reg     <= osd_next;
        ost_reg     <= ost_next;
        oeor_reg    <= oeor_next;
    end

    // output port
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, osd_reg, oval_reg, oidx_reg};
    assign m_tuser  = {ost_reg, okind_reg};
    assign m_tlast  = oeor_reg;

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_busy)
        else $error("divider started while busy");
    a_sqrt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_start_reg |-> !sqrt_busy)
        else $error("square root started while busy");
    a_sub_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == KIND_SUB) |-> !m_tuser[2])
        else $error("subset mean carries error status");
endmodule

// ===== tb/jackknife_mean_error_estimator_core_tb.sv =====
`timescale 1ns / 1ps
// jackknife_mean_error_estimator_core_tb: self-checking bench for the jackknife core
// streams runs of Q16.16 samples and checks every result against a local predictor
// depends on jme_pkg and jackknife_mean_error_estimator_core

module jackknife_mean_error_estimator_core_tb;
    import jme_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  block_index;
        logic [31:0] value;
        logic [30:0] std_dev;
        logic        status;
        logic        end_of_run;
    } estimate_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    jackknife_mean_error_estimator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    sample_t     pending_samples[$];
    estimate_t   expected_estimates[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned quiet_cycles;

    // predictor state
    logic [5:0]  model_blocks;
    logic        model_unbiased;
    logic [31:0] model_store[MAX_SAMPLES];
    int unsigned model_total;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // store one sample; on the last one compute the whole run's estimates
    task automatic predict_jackknife(logic [31:0] sample, logic last);
        int unsigned     nb, n, drop, m;
        longint          bsum[MAX_BLOCKS];
        logic [31:0]     smean[MAX_BLOCKS];
        longint          total, est, bias_sum, dev, bias, res;
        longint unsigned ad, d2, sq, var_q, sd;
        estimate_t       e;
        total = 0; bias_sum = 0; sq = 0;
        if (model_total < MAX_SAMPLES) begin
            model_store[model_total] = sample;
            model_total++;
        end
        if (!last) return;
        n = model_total;
        model_total = 0;
        nb = model_blocks;
        if (nb == 0) nb = 1;
        if (nb > MAX_BLOCKS) nb = MAX_BLOCKS;
        e = '0;
        e.kind = model_unbiased ? KIND_UNB : KIND_EST;
        if (n < nb) begin
            e.status = 1'b1;
            e.end_of_run = 1'b1;
            expected_estimates = {expected_estimates, e};
            return;
        end
        drop = n % nb;
        m = n / nb;
        for (int k = 0; k < nb; k++) begin
            bsum[k] = 0;
            for (int i = 0; i < m; i++)
                bsum[k] += longint'(signed'(model_store[drop + k * m + i]));
            total += bsum[k];
        end
        est = round_div(total, longint'(nb) * m);
        for (int k = 0; k < nb; k++) begin
            if (nb == 1) smean[k] = '0;
            else smean[k] = sat32(round_div(total - bsum[k], longint'(nb - 1) * m));
            bias_sum += longint'(signed'(smean[k]));
            dev = longint'(signed'(smean[k])) - est;
            ad = (dev < 0) ? longint'(-dev) : longint'(dev);
            d2 = ad * ad;
            sq = (sq > 64'hFFFF_FFFF_FFFF_FFFF - d2) ? 64'hFFFF_FFFF_FFFF_FFFF : sq + d2;
        end
        var_q = (sq / nb) * (nb - 1) + ((sq % nb) * (nb - 1)) / nb;
        sd = int_sqrt(var_q);
        if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
        if (model_unbiased) begin
            bias = round_div(bias_sum, nb);
            res = est - longint'(nb - 1) * (bias - est);
        end else begin
            res = est;
        end
        e.value = sat32(res);
        e.std_dev = sd[30:0];
        expected_estimates = {expected_estimates, e};
        for (int k = 0; k < nb; k++) begin
            e = '0;
            e.kind = KIND_SUB;
            e.block_index = k[4:0];
            e.value = smean[k];
            e.end_of_run = (k == nb - 1);
            expected_estimates = {expected_estimates, e};
        end
    endtask

    // input driver: valid stays up across back-to-back transactions
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_samples[0].sample;
                s_tlast  <= pending_samples[0].last;
                void'(pending_samples.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on accepted samples, check accepted results, watch for hangs
    always @(posedge aclk) begin
        estimate_t got, want;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_addr == REG_BLOCK_COUNT) model_blocks = cfg_wdata;
                else model_unbiased = cfg_wdata[0];
            end
            if (s_tvalid && s_tready) predict_jackknife(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.kind        = m_tuser[1:0];
                got.status      = m_tuser[2];
                got.block_index = m_tdata[4:0];
                got.value       = m_tdata[36:5];
                got.std_dev     = m_tdata[67:37];
                got.end_of_run  = m_tlast;
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    error_count++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        error_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic addr, logic [5:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // sender holds off until every result is back and the core has settled
    task automatic drain();
        while (pending_samples.size() != 0 || expected_estimates.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // data styles: 0 full random, 1 small values, 2 positive max, 3 negative min
    task automatic queue_run(int unsigned len, int unsigned style);
        sample_t s;
        for (int unsigned i = 0; i < len; i++) begin
            case (style)
                0: s.sample = $urandom;
                1: s.sample = $urandom_range(32'h0004_0000) - 32'h0002_0000;
                2: s.sample = 32'h7FFF_FFFF;
                default: s.sample = 32'h8000_0000;
            endcase
            s.last = (i == len - 1);
            pending_samples = {pending_samples, s};
        end
    endtask

    task automatic configure(logic [5:0] blocks, logic unbiased);
        drain();
        write_reg(REG_BLOCK_COUNT, blocks);
        write_reg(REG_UNBIASED, unbiased);
    endtask

    // mostly runs long enough for all blocks, some too short
    task automatic random_phase(logic [5:0] blocks, logic unbiased, int unsigned items);
        int unsigned sent, nb, len;
        sent = 0;
        configure(blocks, unbiased);
        nb = (blocks == 0) ? 1 : (blocks > MAX_BLOCKS ? MAX_BLOCKS : blocks);
        while (sent < items) begin
            if ($urandom_range(9) == 0) len = $urandom_range(nb > 1 ? nb - 1 : 1, 1);
            else len = nb + $urandom_range(nb / 2 + 3);
            queue_run(len, $urandom_range(9) < 6 ? 0 : $urandom_range(3));
            sent += len;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_addr = REG_BLOCK_COUNT; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 10; recv_idle_pct = 68;
        error_count = 0; quiet_cycles = 0;
        model_blocks = 6'd1; model_unbiased = 1'b0; model_total = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset defaults, one block, extremes
        queue_run(1, 2);
        queue_run(2, 3);
        queue_run(3, 0);
        // too few samples, dropped leading samples, unbiased
        configure(6'd4, 1'b1);
        queue_run(2, 0);
        queue_run(9, 1);
        queue_run(5, 2);
        // zero block count acts as one, oversized count saturates
        configure(6'd0, 1'b0);
        queue_run(2, 0);
        configure(6'd63, 1'b1);
        queue_run(3, 0);

        random_phase(6'd3, 1'b0, 15);
        random_phase(6'd32, 1'b1, 1);
        drain();
        send_idle_pct = 68; recv_idle_pct = 10;
        random_phase(6'd5, 1'b1, 15);
        random_phase(6'd1, 1'b0, 8);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(6'd2, 1'b1, 10);
        random_phase(6'd7, 1'b0, 12);
        drain();
        repeat (200) @(posedge aclk);

        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (expected_estimates.size() != 0)
                $display("%0t: %0d results never arrived", $time, expected_estimates.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/jme_pkg.sv
sv/jme_ram.sv
sv/jme_div.sv
sv/jme_sqrt.sv
sv/jackknife_mean_error_estimator_core.sv
tb/jackknife_mean_error_estimator_core_tb.sv
